FILE: rtl/arhm_pkg.sv
// Package for the audio ring health monitor.
// Holds the sample and result item types and the field widths shared by the core and the top.
// No dependencies.
`timescale 1ns / 1ps

package arhm_pkg;

	localparam int unsigned CapW = 16;
	localparam int unsigned EpochW = 32;
	localparam int unsigned FieldW = 32;
	localparam int unsigned FillW = 16;
	localparam int unsigned LowW = 15;
	localparam int unsigned EventW = 6;
	localparam int unsigned LossW = 4;

	// Bit positions in event_flags.
	localparam int unsigned EvPressLow = 0;
	localparam int unsigned EvPressHigh = 1;
	localparam int unsigned EvDrop = 2;
	localparam int unsigned EvOverflow = 3;
	localparam int unsigned EvUnderflow = 4;
	localparam int unsigned EvLost = 5;

	typedef struct packed {
		logic              play_active;
		logic [EpochW-1:0] session_epoch;
		logic [EpochW-1:0] stream_epoch;
		logic [FieldW-1:0] blocks_submitted;
		logic [FillW-1:0]  fill_frames;
		logic [FieldW-1:0] drop_count;
		logic [FieldW-1:0] overflow_count;
		logic [FieldW-1:0] underflow_count;
		logic [FieldW-1:0] lost_count;
	} sample_t;

	typedef struct packed {
		logic [LowW-1:0]   low_alarm_level;
		logic [CapW-1:0]   high_alarm_level;
		logic [FieldW-1:0] drop_delta;
		logic [FieldW-1:0] overflow_delta;
		logic [FieldW-1:0] underflow_delta;
		logic [FieldW-1:0] lost_delta;
		logic [EventW-1:0] event_flags;
		logic [LossW-1:0]  latched_loss;
	} result_t;

endpackage

FILE: rtl/arhm_core.sv
// Per-sample evaluation of the ring health: alarm levels, counter deltas, grace and flags.
// Keeps the previous counters, epochs and sticky flags, updated when a sample is taken.
// Depends on arhm_pkg.
`timescale 1ns / 1ps

module arhm_core #(
	parameter int unsigned CNT_W = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  arhm_pkg::sample_t      smp,
	input  logic [arhm_pkg::CapW-1:0] ring_capacity,
	output arhm_pkg::result_t      res
);
	import arhm_pkg::*;

	logic [CNT_W-1:0]  prev_drop_q, prev_ovf_q, prev_und_q, prev_lost_q;
	logic              prev_active_q, seen_first_q, grace_pending_q;
	logic [EpochW-1:0] prev_session_q, prev_stream_q;
	logic [LossW-1:0]  sticky_loss_q;

	logic [CNT_W-1:0]  cur_drop, cur_ovf, cur_und, cur_lost;
	logic [CNT_W-1:0]  gr_drop, gr_ovf, gr_und, gr_lost;
	logic              act, sess_start, strm_start, any_start, avail, p_low, p_high;
	logic              grace_drop, keep_deltas, keep_und;
	logic [LowW-1:0]   lo;
	logic [CapW+3:0]   cap_x15;
	logic [CapW-1:0]   hi;
	logic [EventW-1:0] ev;
	logic [LossW-1:0]  sticky_next;
	logic              grace_next;

	function automatic logic [CNT_W-1:0] grow(input logic [CNT_W-1:0] now_v,
		input logic [CNT_W-1:0] was_v);
		grow = (now_v >= was_v) ? (now_v - was_v) : '0;
	endfunction

	always_comb begin
		act = smp.play_active;
		cur_drop = smp.drop_count[CNT_W-1:0];
		cur_ovf = smp.overflow_count[CNT_W-1:0];
		cur_und = smp.underflow_count[CNT_W-1:0];
		cur_lost = smp.lost_count[CNT_W-1:0];

		lo = ring_capacity[CapW-1:1];
		cap_x15 = {ring_capacity, 4'b0000} - {4'b0000, ring_capacity};
		hi = cap_x15[CapW+3:4];

		sess_start = act && (!seen_first_q || !prev_active_q ||
			smp.session_epoch != prev_session_q);
		strm_start = act && seen_first_q && (smp.stream_epoch != '0) &&
			(smp.stream_epoch != prev_stream_q);
		any_start = sess_start || strm_start;

		avail = (ring_capacity != '0) && (smp.blocks_submitted != '0);
		p_low = avail && (smp.fill_frames < {1'b0, lo});
		p_high = avail && !p_low && (smp.fill_frames > hi);

		// The startup grace drops the underflow delta of the first sample after a start, if the ring has recovered by then.
		grace_drop = !any_start && grace_pending_q && avail && !p_low;

		gr_drop = seen_first_q ? grow(cur_drop, prev_drop_q) : '0;
		gr_ovf = seen_first_q ? grow(cur_ovf, prev_ovf_q) : '0;
		gr_und = seen_first_q ? grow(cur_und, prev_und_q) : '0;
		gr_lost = seen_first_q ? grow(cur_lost, prev_lost_q) : '0;

		keep_deltas = act && !sess_start;
		keep_und = keep_deltas && !strm_start && !grace_drop;

		res.low_alarm_level = lo;
		res.high_alarm_level = hi;
		res.drop_delta = keep_deltas ? FieldW'(gr_drop) : '0;
		res.overflow_delta = keep_deltas ? FieldW'(gr_ovf) : '0;
		res.underflow_delta = keep_und ? FieldW'(gr_und) : '0;
		res.lost_delta = keep_deltas ? FieldW'(gr_lost) : '0;

		ev = '0;
		ev[EvPressLow] = act && p_low;
		ev[EvPressHigh] = act && p_high;
		ev[EvDrop] = res.drop_delta != '0;
		ev[EvOverflow] = res.overflow_delta != '0;
		ev[EvUnderflow] = res.underflow_delta != '0;
		ev[EvLost] = res.lost_delta != '0;
		res.event_flags = ev;

		if (!act) begin
			sticky_next = '0;
		end else begin
			sticky_next = (any_start ? '0 : sticky_loss_q) | ev[EvLost:EvDrop];
		end
		res.latched_loss = sticky_next;
		grace_next = act && any_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_drop_q <= '0;
			prev_ovf_q <= '0;
			prev_und_q <= '0;
			prev_lost_q <= '0;
			prev_active_q <= 1'b0;
			prev_session_q <= '0;
			prev_stream_q <= '0;
			seen_first_q <= 1'b0;
			sticky_loss_q <= '0;
			grace_pending_q <= 1'b0;
		end else if (take) begin
			prev_drop_q <= cur_drop;
			prev_ovf_q <= cur_ovf;
			prev_und_q <= cur_und;
			prev_lost_q <= cur_lost;
			prev_active_q <= act;
			prev_session_q <= smp.session_epoch;
			prev_stream_q <= smp.stream_epoch;
			seen_first_q <= 1'b1;
			sticky_loss_q <= sticky_next;
			grace_pending_q <= grace_next;
		end
	end

	a_press_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.event_flags[EvPressLow] && res.event_flags[EvPressHigh]))
		else $error("low and high pressure flagged together");

	a_grace_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		(take && act && !any_start) |=> !grace_pending_q)
		else $error("grace still pending after a plain active sample");

	a_latched_covers_events: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ((sticky_loss_q & $past(ev[EvLost:EvDrop])) == $past(ev[EvLost:EvDrop])))
		else $error("latched loss flags miss an event of the last sample");

endmodule

FILE: rtl/audio_ring_health_monitor.sv
// Top level of the audio ring health monitor: stream ports, capacity register,
// input register and result register around arhm_core.
// Depends on arhm_pkg and arhm_core.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  sample item (tdata 240 bits, tuser play_active)
// m_*       out        m_tvalid/m_tready  result item (tdata 176 bits)
// cfg_*     in         cfg_valid/cfg_ready ring_capacity (16 bits)
//
// One item per cycle sustained while m_tready is high; an accepted item is loaded into the input register,
// then into the result register, which raises m_tvalid, once the output can take it.
// The core state is updated as the item moves from the input register to the result register.
// Reset clears the capacity, the core state and both valid flags.
// A stalled output holds its item while one more item waits in the input register.
`timescale 1ns / 1ps

module audio_ring_health_monitor #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] session_epoch, [63:32] stream_epoch, [95:64] blocks_submitted,
	// [111:96] fill_frames, [143:112] drop_count, [175:144] overflow_count,
	// [207:176] underflow_count, [239:208] lost_count
	input  logic [239:0] s_tdata,
	// [0] play_active
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [14:0] low_alarm_level, [30:15] high_alarm_level, [62:31] drop_delta,
	// [94:63] overflow_delta, [126:95] underflow_delta, [158:127] lost_delta,
	// [164:159] event_flags, [168:165] latched_loss, [175:169] zero
	output logic [175:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);
	import arhm_pkg::*;

	localparam int unsigned CntW = (COUNT_WIDTH < FieldW) ? COUNT_WIDTH : FieldW;

	logic [CapW-1:0] capacity_q;
	logic            valid_s1, out_valid_q, advance;
	sample_t         smp_s1;
	result_t         res, res_q;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			smp_s1.play_active <= s_tuser;
			smp_s1.session_epoch <= s_tdata[31:0];
			smp_s1.stream_epoch <= s_tdata[63:32];
			smp_s1.blocks_submitted <= s_tdata[95:64];
			smp_s1.fill_frames <= s_tdata[111:96];
			smp_s1.drop_count <= s_tdata[143:112];
			smp_s1.overflow_count <= s_tdata[175:144];
			smp_s1.underflow_count <= s_tdata[207:176];
			smp_s1.lost_count <= s_tdata[239:208];
		end
		if (advance) begin
			res_q <= res;
		end
	end

	arhm_core #(
		.CNT_W(CntW)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (advance),
		.smp          (smp_s1),
		.ring_capacity(capacity_q),
		.res          (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'b0, res_q.latched_loss, res_q.event_flags, res_q.lost_delta,
		res_q.underflow_delta, res_q.overflow_delta, res_q.drop_delta,
		res_q.high_alarm_level, res_q.low_alarm_level};

endmodule

FILE: tb/tb.sv
// Self-checking testbench for audio_ring_health_monitor.
// Drives health samples and capacity writes, predicts every result item, checks them in order.
// Depends on arhm_pkg and the RTL of audio_ring_health_monitor.
`timescale 1ns / 1ps

module tb;
	import arhm_pkg::*;

	localparam int CYCLE_LIMIT = 250000;
	localparam int PHASE_ITEMS = 190;
	localparam int PHASES = 10;
	localparam int REPORT_CAP = 40;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [239:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [175:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;

	audio_ring_health_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow of the monitor state, updated once per accepted sample.
	logic [15:0]       ring_cap = '0;
	logic [3:0][31:0]  last_cnt = '0;
	logic              last_active = 1'b0;
	logic [31:0]       last_session = '0;
	logic [31:0]       last_stream = '0;
	logic              have_history = 1'b0;
	logic [LossW-1:0]  loss_latch = '0;
	logic              grace_armed = 1'b0;

	sample_t     sample_backlog [$];
	result_t     expected_reports [$];
	logic [15:0] cap_writes [$];
	sample_t     in_flight;

	int  send_wait = 0;
	int  take_wait = 0;
	bit  calm = 1'b0;
	int  mismatches = 0;
	int  samples_sent = 0;
	int  samples_queued = 0;
	int  results_checked = 0;
	int  cap_settings = 0;
	int  cycle_count = 0;

	// Stimulus state for the well-formed playback sequences.
	logic [31:0]      sess_no = 32'd100;
	logic [31:0]      strm_no = 32'd1;
	logic [3:0][31:0] ctr = '0;

	function automatic result_t predict_report(input sample_t s);
		result_t          r;
		logic [3:0][31:0] now_cnt;
		logic [3:0][31:0] delta;
		logic [19:0]      cap15;
		logic             sess_start, strm_start, avail, p_low, p_high;
		logic [EventW-1:0] ev;
		int               k;
		r = '0;
		ev = '0;
		now_cnt = {s.lost_count, s.underflow_count, s.overflow_count, s.drop_count};
		r.low_alarm_level = ring_cap[15:1];
		cap15 = {4'b0, ring_cap} * 20'd15;
		r.high_alarm_level = cap15[19:4];
		sess_start = s.play_active &&
			(!have_history || !last_active || s.session_epoch != last_session);
		strm_start = s.play_active && have_history && s.stream_epoch != 0 &&
			s.stream_epoch != last_stream;
		for (k = 0; k < 4; k++) begin
			delta[k] = (have_history && now_cnt[k] >= last_cnt[k]) ?
				now_cnt[k] - last_cnt[k] : 32'd0;
		end
		last_cnt = now_cnt;
		last_active = s.play_active;
		last_session = s.session_epoch;
		last_stream = s.stream_epoch;
		have_history = 1'b1;
		if (!s.play_active) begin
			loss_latch = '0;
			grace_armed = 1'b0;
			delta = '0;
		end else begin
			if (sess_start) begin
				loss_latch = '0;
				grace_armed = 1'b1;
				delta = '0;
			end else if (strm_start) begin
				loss_latch = '0;
				grace_armed = 1'b1;
				delta[2] = '0;
			end
			avail = ring_cap != 0 && s.blocks_submitted != 0;
			p_low = avail && s.fill_frames < {1'b0, r.low_alarm_level};
			p_high = avail && !p_low && s.fill_frames > r.high_alarm_level;
			// The first ordinary sample after a start forgives underflow once the
			// ring has recovered.
			if (!sess_start && !strm_start && grace_armed) begin
				if (avail && !p_low)
					delta[2] = '0;
				grace_armed = 1'b0;
			end
			ev[EvPressLow] = p_low;
			ev[EvPressHigh] = p_high;
			ev[EvDrop] = delta[0] != 0;
			ev[EvOverflow] = delta[1] != 0;
			ev[EvUnderflow] = delta[2] != 0;
			ev[EvLost] = delta[3] != 0;
			loss_latch = loss_latch | ev[EvLost:EvDrop];
			r.latched_loss = loss_latch;
		end
		r.drop_delta = delta[0];
		r.overflow_delta = delta[1];
		r.underflow_delta = delta[2];
		r.lost_delta = delta[3];
		r.event_flags = ev;
		return r;
	endfunction

	// Wait before the next item; occasionally flips into a stretch with no gaps.
	function automatic int pick_wait();
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic logic [15:0] pick_fill(input logic [15:0] cap);
		int lo, hi, v;
		lo = cap / 2;
		hi = (cap * 15) / 16;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = lo - 1;
			2: v = lo;
			3: v = hi;
			4: v = hi + 1;
			5: v = $urandom_range(0, cap);
			6: v = 65535;
			default: v = $urandom;
		endcase
		return v[15:0];
	endfunction

	function automatic logic [31:0] advance_counter(input logic [31:0] c);
		case ($urandom_range(0, 15))
			9, 10, 11, 12: return c + $urandom_range(1, 10);
			13: return c + $urandom;
			14: return $urandom_range(0, c);
			15: return $urandom;
			default: return c;
		endcase
	endfunction

	task automatic queue_sample(input logic act, input logic [31:0] sess, input logic [31:0] strm,
			input logic [31:0] blocks, input logic [15:0] fill, input logic [31:0] drops,
			input logic [31:0] ovf, input logic [31:0] und, input logic [31:0] lost);
		sample_t s;
		s.play_active = act;
		s.session_epoch = sess;
		s.stream_epoch = strm;
		s.blocks_submitted = blocks;
		s.fill_frames = fill;
		s.drop_count = drops;
		s.overflow_count = ovf;
		s.underflow_count = und;
		s.lost_count = lost;
		sample_backlog.push_back(s);
		samples_queued++;
	endtask

	// Mostly sessions of active samples with growing counters; the rest is noise.
	task automatic queue_ring_traffic(input int n, input logic [15:0] cap);
		int left, run, i, k;
		logic [31:0] blocks;
		left = n;
		while (left > 0) begin
			case ($urandom_range(0, 3))
				0: begin
					queue_sample(1'b0, sess_no, strm_no, $urandom, pick_fill(cap),
						ctr[0], ctr[1], ctr[2], ctr[3]);
					left--;
				end
				1: sess_no = sess_no + 1;
				2: sess_no = $urandom;
				default: ;
			endcase
			run = $urandom_range(1, 40);
			for (i = 0; i < run && left > 0; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_sample(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
						16'($urandom), $urandom, $urandom, $urandom, $urandom);
				end else begin
					if ($urandom_range(0, 15) == 0)
						strm_no = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
					for (k = 0; k < 4; k++)
						ctr[k] = advance_counter(ctr[k]);
					case ($urandom_range(0, 19))
						0: blocks = 0;
						1: blocks = $urandom;
						default: blocks = $urandom_range(1, 5000);
					endcase
					queue_sample(1'b1, sess_no, strm_no, blocks, pick_fill(cap),
						ctr[0], ctr[1], ctr[2], ctr[3]);
				end
				left--;
			end
		end
	endtask

	// Every queued sample must come back as a checked result before moving on.
	task automatic wait_idle();
		while (results_checked < samples_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] cap);
		int target;
		target = cap_settings + 1;
		cap_writes.push_back(cap);
		while (cap_settings < target)
			@(posedge clk);
	endtask

	function automatic logic [15:0] plan_capacity(input int p);
		case (p)
			0: return 16'hFFFF;
			1: return 16'd0;
			2: return 16'd1;
			3: return 16'd2;
			4: return 16'd16;
			5: return 16'd17;
			6: return 16'd100;
			7: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Sample driver.
	always @(posedge clk) begin
		sample_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_reports.push_back(predict_report(in_flight));
				samples_sent++;
			end
			if (s_tvalid && !s_tready) begin
				// Item still waiting for acceptance; hold everything.
			end else if (send_wait > 0) begin
				send_wait--;
				s_tvalid <= 1'b0;
			end else if (sample_backlog.size() != 0) begin
				nxt = sample_backlog.pop_front();
				in_flight = nxt;
				s_tvalid <= 1'b1;
				s_tdata <= {nxt.lost_count, nxt.underflow_count, nxt.overflow_count,
					nxt.drop_count, nxt.fill_frames, nxt.blocks_submitted,
					nxt.stream_epoch, nxt.session_epoch};
				s_tuser <= nxt.play_active;
				send_wait = pick_wait();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Capacity register writes.
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			ring_cap = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ring_cap = cfg_data;
				cap_settings++;
			end
			if ((!cfg_valid || cfg_ready) && cap_writes.size() != 0) begin
				cfg_valid <= 1'b1;
				cfg_data <= cap_writes.pop_front();
			end else if (cfg_valid && cfg_ready) begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: result with no sample waiting, expected none, got %h",
							$time, m_tdata);
				end else begin
					want = expected_reports.pop_front();
					check_field("low_alarm_level", 32'(want.low_alarm_level),
						32'(m_tdata[14:0]));
					check_field("high_alarm_level", 32'(want.high_alarm_level),
						32'(m_tdata[30:15]));
					check_field("drop_delta", want.drop_delta, m_tdata[62:31]);
					check_field("overflow_delta", want.overflow_delta, m_tdata[94:63]);
					check_field("underflow_delta", want.underflow_delta, m_tdata[126:95]);
					check_field("lost_delta", want.lost_delta, m_tdata[158:127]);
					check_field("event_flags", 32'(want.event_flags), 32'(m_tdata[164:159]));
					check_field("latched_loss", 32'(want.latched_loss), 32'(m_tdata[168:165]));
					check_field("tdata padding", '0, 32'(m_tdata[175:169]));
					results_checked++;
				end
				take_wait = pick_wait();
			end
			if (take_wait > 0) begin
				take_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int p;
		logic [15:0] cap;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Capacity still at its reset value: the first sample ever, then a grace
		// sample on a ring that cannot count as recovered.
		queue_sample(1'b1, 32'd1, 32'd1, 32'd5, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		queue_sample(1'b1, 32'd1, 32'd1, 32'd5, 16'd0, 32'd2, 32'd2, 32'd2, 32'd2);
		wait_idle();

		// Capacity 64: low level 32, high level 60.
		write_capacity(16'd64);
		queue_sample(1'b1, 32'd1, 32'd1, 32'd9, 16'd40, 32'd3, 32'd3, 32'd3, 32'd3);
		queue_sample(1'b1, 32'd2, 32'd1, 32'd9, 16'd31, 32'd4, 32'd4, 32'd4, 32'd4);
		queue_sample(1'b1, 32'd2, 32'd1, 32'd9, 16'd32, 32'd8, 32'd8, 32'd8, 32'd8);
		queue_sample(1'b1, 32'd2, 32'd1, 32'd9, 16'd60, 32'd8, 32'd8, 32'd9, 32'd8);
		queue_sample(1'b1, 32'd2, 32'd7, 32'd9, 16'd61, 32'd9, 32'd9, 32'd12, 32'd9);
		queue_sample(1'b1, 32'd2, 32'd7, 32'd9, 16'd5, 32'd9, 32'd9, 32'd15, 32'd9);
		queue_sample(1'b1, 32'd2, 32'd0, 32'd0, 16'd5, 32'd0, 32'd10, 32'd15, 32'd9);
		queue_sample(1'b0, 32'd2, 32'd0, 32'd9, 16'd40, 32'd50, 32'd50, 32'd50, 32'd50);
		queue_sample(1'b1, 32'd2, 32'd0, 32'd9, 16'd40, 32'd51, 32'd51, 32'd51, 32'd51);
		queue_sample(1'b1, 32'd2, 32'd0, 32'd0, 16'd40, 32'd51, 32'd51, 32'd60, 32'd51);
		queue_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0,
			32'd0, 32'd0, 32'd0, 32'd0);
		queue_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_sample(1'b0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		queue_sample(1'b1, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		queue_sample(1'b1, 32'd0, 32'd3, 32'd1, 16'd33, 32'd1, 32'd1, 32'd1, 32'd1);
		queue_sample(1'b1, 32'd6, 32'd4, 32'd1, 16'd33, 32'd2, 32'd2, 32'd2, 32'd2);
		wait_idle();

		for (p = 0; p < PHASES; p++) begin
			cap = plan_capacity(p);
			write_capacity(cap);
			queue_ring_traffic(PHASE_ITEMS, cap);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d health samples across %0d capacity settings, extremes included.",
			samples_sent, cap_settings);
		$display("Checked %0d result items field by field; %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
